// ----- hw/rtl/ralu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ralu_pkg;

   // Operation codes.
   localparam logic [4:0] CMD_ADD    = 5'd0;
   localparam logic [4:0] CMD_SUB    = 5'd1;
   localparam logic [4:0] CMD_SLL    = 5'd2;
   localparam logic [4:0] CMD_SLT    = 5'd3;
   localparam logic [4:0] CMD_SLTU   = 5'd4;
   localparam logic [4:0] CMD_XOR    = 5'd5;
   localparam logic [4:0] CMD_SRL    = 5'd6;
   localparam logic [4:0] CMD_SRA    = 5'd7;
   localparam logic [4:0] CMD_OR     = 5'd8;
   localparam logic [4:0] CMD_AND    = 5'd9;
   localparam logic [4:0] CMD_MUL    = 5'd10;
   localparam logic [4:0] CMD_MULH   = 5'd11;
   localparam logic [4:0] CMD_MULHSU = 5'd12;
   localparam logic [4:0] CMD_MULHU  = 5'd13;
   localparam logic [4:0] CMD_DIV    = 5'd14;
   localparam logic [4:0] CMD_DIVU   = 5'd15;
   localparam logic [4:0] CMD_REM    = 5'd16;
   localparam logic [4:0] CMD_REMU   = 5'd17;
   localparam logic [4:0] CMD_ADDW   = 5'd18;
   localparam logic [4:0] CMD_SUBW   = 5'd19;
   localparam logic [4:0] CMD_SLLW   = 5'd20;
   localparam logic [4:0] CMD_SRLW   = 5'd21;
   localparam logic [4:0] CMD_SRAW   = 5'd22;
   localparam logic [4:0] CMD_MULW   = 5'd23;
   localparam logic [4:0] CMD_DIVW   = 5'd24;
   localparam logic [4:0] CMD_DIVUW  = 5'd25;
   localparam logic [4:0] CMD_REMW   = 5'd26;
   localparam logic [4:0] CMD_REMUW  = 5'd27;

   // Execution unit that carries out an operation.
   typedef enum logic [1:0] {
      UNIT_FAST = 2'd0,
      UNIT_MUL  = 2'd1,
      UNIT_DIV  = 2'd2
   } unit_type;

   // One classified operation as it sits in the queue.
   typedef struct packed {
      logic [4:0]  cmd;
      unit_type    unit;
      logic        word;
      logic        want_rem;
      logic        sgn_a;
      logic        sgn_b;
      logic [63:0] a;
      logic [63:0] b;
   } entry_type;

   // Sign-extend the low 32 bits to 64 bits.
   function automatic logic [63:0] sext32(input logic [63:0] x);
      sext32 = {{32{x[31]}}, x[31:0]};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ralu_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ralu_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [4:0]          cmd,
   input  wire logic [63:0]         operand_a,
   input  wire logic [63:0]         operand_b,
   output ralu_pkg::entry_type      push_entry,
   output logic                     push_valid
);

   logic                valid_ff;
   ralu_pkg::entry_type entry_ff;
   ralu_pkg::entry_type entry_in;

   // Classify the command by unit and by its signedness and width.
   always_comb begin
      entry_in          = '0;
      entry_in.cmd      = cmd;
      entry_in.a        = operand_a;
      entry_in.b        = operand_b;
      entry_in.unit     = ralu_pkg::UNIT_FAST;
      entry_in.word     = (cmd >= ralu_pkg::CMD_ADDW);
      unique case (cmd)
         ralu_pkg::CMD_MUL, ralu_pkg::CMD_MULHU, ralu_pkg::CMD_MULW: begin
            entry_in.unit = ralu_pkg::UNIT_MUL;
         end
         ralu_pkg::CMD_MULH: begin
            entry_in.unit  = ralu_pkg::UNIT_MUL;
            entry_in.sgn_a = 1'b1;
            entry_in.sgn_b = 1'b1;
         end
         ralu_pkg::CMD_MULHSU: begin
            entry_in.unit  = ralu_pkg::UNIT_MUL;
            entry_in.sgn_a = 1'b1;
         end
         ralu_pkg::CMD_DIV, ralu_pkg::CMD_DIVW: begin
            entry_in.unit  = ralu_pkg::UNIT_DIV;
            entry_in.sgn_a = 1'b1;
            entry_in.sgn_b = 1'b1;
         end
         ralu_pkg::CMD_REM, ralu_pkg::CMD_REMW: begin
            entry_in.unit     = ralu_pkg::UNIT_DIV;
            entry_in.sgn_a    = 1'b1;
            entry_in.sgn_b    = 1'b1;
            entry_in.want_rem = 1'b1;
         end
         ralu_pkg::CMD_DIVU, ralu_pkg::CMD_DIVUW: begin
            entry_in.unit = ralu_pkg::UNIT_DIV;
         end
         ralu_pkg::CMD_REMU, ralu_pkg::CMD_REMUW: begin
            entry_in.unit     = ralu_pkg::UNIT_DIV;
            entry_in.want_rem = 1'b1;
         end
         default: begin
            entry_in.unit = ralu_pkg::UNIT_FAST;
         end
      endcase
   end

   // Stage register between the command ports and the queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_entry = entry_ff;
   assign push_valid = valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ralu_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ralu_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire ralu_pkg::entry_type        push_entry,
   input  wire logic                       pop,
   output ralu_pkg::entry_type             head_entry,
   output logic                            head_valid,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

   ralu_pkg::entry_type mem_ff [DEPTH];
   logic [IW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff, count_in;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + IW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + IW'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign head_entry = mem_ff[rd_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ralu_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ralu_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ralu_pkg::entry_type head_entry,
   input  wire logic           head_valid,
   output logic                pop,
   output logic                rsp_valid,
   output logic [63:0]         rsp_result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   ralu_pkg::entry_type cur_ff, cur_in;
   logic [127:0]        acc_ff, acc_in;
   logic [63:0]         dq_ff, dq_in, drem_ff, drem_in, dd_ff, dd_in;
   logic [63:0]         dx_ff, dx_in;
   logic                qneg_ff, qneg_in, rneg_ff, rneg_in, zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_result_ff, rsp_result_in;

   logic [63:0]  fast_res, fin_res;
   logic [63:0]  dx, dy, ma, mb;
   logic         na, nb;
   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [7:0]   pp_sh;
   logic [64:0]  dsh, ddiff;
   logic [63:0]  mhi, qres, rres, dres;

   // Fast operations computed combinationally straight from the queue head.
   always_comb begin
      logic [63:0] a, b;
      a = head_entry.a;
      b = head_entry.b;
      unique case (head_entry.cmd)
         ralu_pkg::CMD_ADD:  fast_res = a + b;
         ralu_pkg::CMD_SUB:  fast_res = a - b;
         ralu_pkg::CMD_SLL:  fast_res = a << b[5:0];
         ralu_pkg::CMD_SLT:  fast_res = {63'd0, $signed(a) < $signed(b)};
         ralu_pkg::CMD_SLTU: fast_res = {63'd0, a < b};
         ralu_pkg::CMD_XOR:  fast_res = a ^ b;
         ralu_pkg::CMD_SRL:  fast_res = a >> b[5:0];
         ralu_pkg::CMD_SRA:  fast_res = $unsigned($signed(a) >>> b[5:0]);
         ralu_pkg::CMD_OR:   fast_res = a | b;
         ralu_pkg::CMD_AND:  fast_res = a & b;
         ralu_pkg::CMD_ADDW: fast_res = ralu_pkg::sext32(a + b);
         ralu_pkg::CMD_SUBW: fast_res = ralu_pkg::sext32(a - b);
         ralu_pkg::CMD_SLLW: fast_res = ralu_pkg::sext32(a << b[4:0]);
         ralu_pkg::CMD_SRLW: fast_res = ralu_pkg::sext32({32'd0, a[31:0] >> b[4:0]});
         ralu_pkg::CMD_SRAW: fast_res =
            ralu_pkg::sext32({32'd0, $unsigned($signed(a[31:0]) >>> b[4:0])});
         default:            fast_res = '0;
      endcase
   end

   // Divider operand preparation: width, sign and magnitudes.
   always_comb begin
      if (head_entry.word) begin
         dx = head_entry.sgn_a ? ralu_pkg::sext32(head_entry.a)
                               : {32'd0, head_entry.a[31:0]};
         dy = head_entry.sgn_b ? ralu_pkg::sext32(head_entry.b)
                               : {32'd0, head_entry.b[31:0]};
      end else begin
         dx = head_entry.a;
         dy = head_entry.b;
      end
      na = head_entry.sgn_a & dx[63];
      nb = head_entry.sgn_b & dy[63];
      ma = na ? (64'd0 - dx) : dx;
      mb = nb ? (64'd0 - dy) : dy;
   end

   // One 32x32 partial product per cycle, chosen by the step count.
   always_comb begin
      pa    = cnt_ff[1] ? cur_ff.a[63:32] : cur_ff.a[31:0];
      pb    = (cnt_ff[1:0] == 2'd1 || cnt_ff[1:0] == 2'd3) ? cur_ff.b[63:32]
                                                            : cur_ff.b[31:0];
      pp    = {32'd0, pa} * {32'd0, pb};
      pp_sh = (cnt_ff[1:0] == 2'd0) ? 8'd0 : ((cnt_ff[1:0] == 2'd3) ? 8'd64 : 8'd32);
   end

   // One restoring divide step.
   always_comb begin
      dsh   = {drem_ff, dq_ff[63]};
      ddiff = dsh - {1'b0, dd_ff};
   end

   // Final result of a multiply or divide operation.
   always_comb begin
      mhi = acc_ff[127:64]
            - ((cur_ff.sgn_a && cur_ff.a[63]) ? cur_ff.b : 64'd0)
            - ((cur_ff.sgn_b && cur_ff.b[63]) ? cur_ff.a : 64'd0);
      qres = zero_ff ? '1 : (qneg_ff ? (64'd0 - dq_ff) : dq_ff);
      rres = zero_ff ? dx_ff : (rneg_ff ? (64'd0 - drem_ff) : drem_ff);
      dres = cur_ff.want_rem ? rres : qres;
      if (cur_ff.unit == ralu_pkg::UNIT_MUL) begin
         if (cur_ff.cmd == ralu_pkg::CMD_MUL) begin
            fin_res = acc_ff[63:0];
         end else if (cur_ff.cmd == ralu_pkg::CMD_MULW) begin
            fin_res = ralu_pkg::sext32(acc_ff[63:0]);
         end else begin
            fin_res = mhi;
         end
      end else begin
         fin_res = cur_ff.word ? ralu_pkg::sext32(dres) : dres;
      end
   end

   // Sequencer for the back end.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      acc_in        = acc_ff;
      dq_in         = dq_ff;
      drem_in       = drem_ff;
      dd_in         = dd_ff;
      dx_in         = dx_ff;
      qneg_in       = qneg_ff;
      rneg_in       = rneg_ff;
      zero_in       = zero_ff;
      pop           = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               cur_in = head_entry;
               cnt_in = '0;
               unique case (head_entry.unit)
                  ralu_pkg::UNIT_MUL: begin
                     acc_in   = '0;
                     state_in = ST_MUL;
                  end
                  ralu_pkg::UNIT_DIV: begin
                     dq_in    = ma;
                     drem_in  = '0;
                     dd_in    = mb;
                     dx_in    = dx;
                     zero_in  = (dy == 64'd0);
                     qneg_in  = na ^ nb;
                     rneg_in  = na;
                     state_in = ST_DIV;
                  end
                  default: begin
                     pop           = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = fast_res;
                  end
               endcase
            end
         end
         ST_MUL: begin
            acc_in = acc_ff + ({64'd0, pp} << pp_sh);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (!ddiff[64]) begin
               drem_in = ddiff[63:0];
            end else begin
               drem_in = dsh[63:0];
            end
            dq_in  = {dq_ff[62:0], ~ddiff[64]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            pop           = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_result_in = fin_res;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      cur_ff        <= cur_in;
      acc_ff        <= acc_in;
      dq_ff         <= dq_in;
      drem_ff       <= drem_in;
      dd_ff         <= dd_in;
      dx_ff         <= dx_in;
      qneg_ff       <= qneg_in;
      rneg_ff       <= rneg_in;
      zero_ff       <= zero_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // Every retired transaction shows exactly one strobe in the next cycle.
   a_pop_strobe: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("retired transaction without a result strobe");

   // The entry being worked on stays at the head of the queue.
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> head_valid)
      else $error("queue head lost during a multi-cycle operation");

   // The divider finishes after its last step.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == 6'd63) |=> (state_ff == ST_FIN))
      else $error("divider did not finish on its last step");

endmodule

`default_nettype wire

// ----- hw/rtl/rv64im_integer_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake           Payload
// request    start, busy         req_command, req_operand_a, req_operand_b
// response   rsp_valid (strobe)  rsp_result
//
// A transaction is taken when start is high and busy is low; it is classified,
// queued, and executed in order. Add, logic, shift and compare operations pass the
// front stage register, the queue and the response register, and sustain one per
// cycle while no multiply or divide is ahead. Multiplies occupy the back end for
// a load step, four 32x32 partial products and a final correction; divides and
// remainders for a load step, one quotient bit per cycle (64 in all), and a final
// sign fix. busy rises once the queued entries plus the one in the front stage
// reach QUEUE_DEPTH; the receiver cannot stall, so only long operations cause it.
// Reset is synchronous and empties the queue; the result strobe lasts one cycle.

module rv64im_integer_alu #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [4:0]  req_command,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   output logic             rsp_valid,
   output logic [63:0]      rsp_result
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   ralu_pkg::entry_type push_entry, head_entry;
   logic                push_valid, head_valid, pop, accept;
   logic [CW-1:0]       count;

   // Room is reserved for the transaction held in the front stage.
   assign busy   = ({1'b0, count} + {{CW{1'b0}}, push_valid}) >= (CW + 1)'(QUEUE_DEPTH);
   assign accept = start && !busy;

   ralu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_command),
      .operand_a  (req_operand_a),
      .operand_b  (req_operand_b),
      .push_entry (push_entry),
      .push_valid (push_valid)
   );

   ralu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .count      (count)
   );

   ralu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // One pending ALU transaction.
   typedef struct {
      logic [4:0]  cmd;
      logic [63:0] a;
      logic [63:0] b;
   } alu_op_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_command;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_valid;
   logic [63:0] rsp_result;

   alu_op_type  pending_ops[$];
   logic [63:0] expected_results[$];
   int          mismatch_count;
   int          burst_left;
   int          gap_left;

   rv64im_integer_alu DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_result(rsp_result)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Sign-extend the low word of a value.
   function automatic logic [63:0] widen_word(input logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   // Signed quotient or remainder with the RISC-V zero and overflow rules.
   function automatic logic [63:0] signed_divide(input logic [63:0] a, input logic [63:0] b,
                                                 input bit want_rem);
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      sa = a;
      sb = b;
      if (b == 64'd0) return want_rem ? a : '1;
      if (a == 64'h8000_0000_0000_0000 && b == '1)
         return want_rem ? 64'd0 : a;
      return want_rem ? 64'(sa % sb) : 64'(sa / sb);
   endfunction

   // Expected destination value for one operation.
   function automatic logic [63:0] alu_result(input alu_op_type op);
      logic [127:0]        prod;
      logic signed [127:0] sprod;
      logic [63:0]         a32;
      logic [63:0]         b32;
      a32 = {32'd0, op.a[31:0]};
      b32 = {32'd0, op.b[31:0]};
      case (op.cmd)
         ralu_pkg::CMD_ADD:  return op.a + op.b;
         ralu_pkg::CMD_SUB:  return op.a - op.b;
         ralu_pkg::CMD_SLL:  return op.a << op.b[5:0];
         ralu_pkg::CMD_SLT:  return {63'd0, $signed(op.a) < $signed(op.b)};
         ralu_pkg::CMD_SLTU: return {63'd0, op.a < op.b};
         ralu_pkg::CMD_XOR:  return op.a ^ op.b;
         ralu_pkg::CMD_SRL:  return op.a >> op.b[5:0];
         ralu_pkg::CMD_SRA:  return 64'($signed(op.a) >>> op.b[5:0]);
         ralu_pkg::CMD_OR:   return op.a | op.b;
         ralu_pkg::CMD_AND:  return op.a & op.b;
         ralu_pkg::CMD_MUL:  return op.a * op.b;
         ralu_pkg::CMD_MULH: begin
            sprod = $signed({{64{op.a[63]}}, op.a}) * $signed({{64{op.b[63]}}, op.b});
            return sprod[127:64];
         end
         ralu_pkg::CMD_MULHSU: begin
            sprod = $signed({{64{op.a[63]}}, op.a}) * $signed({64'd0, op.b});
            return sprod[127:64];
         end
         ralu_pkg::CMD_MULHU: begin
            prod = {64'd0, op.a} * {64'd0, op.b};
            return prod[127:64];
         end
         ralu_pkg::CMD_DIV:   return signed_divide(op.a, op.b, 1'b0);
         ralu_pkg::CMD_DIVU:  return (op.b == 64'd0) ? '1 : op.a / op.b;
         ralu_pkg::CMD_REM:   return signed_divide(op.a, op.b, 1'b1);
         ralu_pkg::CMD_REMU:  return (op.b == 64'd0) ? op.a : op.a % op.b;
         ralu_pkg::CMD_ADDW:  return widen_word(op.a + op.b);
         ralu_pkg::CMD_SUBW:  return widen_word(op.a - op.b);
         ralu_pkg::CMD_SLLW:  return widen_word(op.a << op.b[4:0]);
         ralu_pkg::CMD_SRLW:  return widen_word(a32 >> op.b[4:0]);
         ralu_pkg::CMD_SRAW:
            return widen_word(64'($signed(widen_word(op.a)) >>> op.b[4:0]));
         ralu_pkg::CMD_MULW:  return widen_word(op.a * op.b);
         ralu_pkg::CMD_DIVW:
            return widen_word(signed_divide(widen_word(op.a), widen_word(op.b), 1'b0));
         ralu_pkg::CMD_DIVUW:
            return widen_word((b32 == 64'd0) ? 64'hFFFF_FFFF : a32 / b32);
         ralu_pkg::CMD_REMW:
            return widen_word(signed_divide(widen_word(op.a), widen_word(op.b), 1'b1));
         ralu_pkg::CMD_REMUW: return widen_word((b32 == 64'd0) ? a32 : a32 % b32);
         default:             return 64'd0;
      endcase
   endfunction

   // Operand with a bias toward corner values.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return widen_word(64'h8000_0000);
         4: return 64'($urandom_range(0, 70));
         5: return widen_word(64'($urandom));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Directed corners, then random transactions.
   initial begin
      logic [63:0] corners[6];
      alu_op_type  op;
      corners = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_8000_0000, 64'd1};
      for (int c = 0; c < 32; c++) begin
         op.cmd = 5'(c);
         op.a = corners[c % 6];
         op.b = corners[(c / 6 + c) % 6];
         if (c < 25 || c > 27) pending_ops.push_back(op);
      end
      // Division zero and overflow cases at both widths.
      op.a = 64'h8000_0000_0000_0000; op.b = '1;
      op.cmd = ralu_pkg::CMD_DIV;  pending_ops.push_back(op);
      op.cmd = ralu_pkg::CMD_REM;  pending_ops.push_back(op);
      op.a = 64'h1234_5678_8000_0000; op.b = 64'h0000_0001_FFFF_FFFF;
      op.cmd = ralu_pkg::CMD_DIVW; pending_ops.push_back(op);
      op.cmd = ralu_pkg::CMD_REMW; pending_ops.push_back(op);
      op.b = 64'hFFFF_FFFF_0000_0000;
      op.cmd = ralu_pkg::CMD_DIVUW; pending_ops.push_back(op);
      op.cmd = ralu_pkg::CMD_REMUW; pending_ops.push_back(op);
      op.cmd = ralu_pkg::CMD_DIVU;  op.b = 64'd0; pending_ops.push_back(op);
      op.cmd = ralu_pkg::CMD_REMU;  pending_ops.push_back(op);
      for (int i = 0; i < 1200; i++) begin
         op.cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(28, 31))
                                                : 5'($urandom_range(0, 27));
         op.a = pick_operand();
         op.b = pick_operand();
         pending_ops.push_back(op);
      end
   end

   // Driver: bursts of transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_command <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         if (start) expected_results.push_back(alu_result('{req_command, req_operand_a,
                                                            req_operand_b}));
         if (gap_left > 0 || pending_ops.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            start <= 1'b1;
            req_command <= pending_ops[0].cmd;
            req_operand_a <= pending_ops[0].a;
            req_operand_b <= pending_ops[0].b;
            void'(pending_ops.pop_front());
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result %h with no transaction pending", rsp_result);
         end else begin
            if (rsp_result !== expected_results[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result mismatch: expected %h, got %h",
                           expected_results[0], rsp_result);
            end
            void'(expected_results.pop_front());
         end
      end
   end

   // Reset, then wait for the stimulus to drain.
   initial begin
      mismatch_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      wait (pending_ops.size() == 0 && !start && expected_results.size() == 0);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog for a hung design.
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
